// ===== hw/rtl/linear_probe_hash_table_defines.svh =====
// Assertion macros of the hash table RTL.
`ifndef LINEAR_PROBE_HASH_TABLE_DEFINES_SVH
`define LINEAR_PROBE_HASH_TABLE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LPHT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lpht assertion failed");

// Next-cycle implication, checked outside reset.
`define LPHT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lpht assertion failed");

`endif

// ===== hw/rtl/lpht_pkg.sv =====
// Types and constants of the linear probing hash table.
`default_nettype none
package lpht_pkg;
   localparam int SLOTS   = 1024;
   localparam int SLOT_AW = $clog2(SLOTS);
   localparam int CNT_W   = 11;
   localparam int HASH_W  = 32;
   localparam int KEY_W   = 32;
   localparam int VAL_W   = 32;
   localparam int MOD_CW  = $clog2(HASH_W);
   localparam int CFG_RESET = 1021;

   typedef enum logic [1:0] {
      ACT_INSERT = 2'd0,
      ACT_SEARCH = 2'd1,
      ACT_REMOVE = 2'd2,
      ACT_CLEAR  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_FOUND  = 2'd1,
      ST_ABSENT = 2'd2,
      ST_FULL   = 2'd3
   } status_type;

   typedef struct packed {
      logic [HASH_W-1:0] hash;
      logic [KEY_W-1:0]  key;
      logic [VAL_W-1:0]  value;
   } slot_type;

   typedef struct packed {
      logic              start;
      logic [HASH_W-1:0] dividend;
      logic [CNT_W-1:0]  divisor;
   } mod_req_type;

   typedef struct packed {
      logic             done;
      logic [CNT_W-1:0] rem;
   } mod_rsp_type;
endpackage
`default_nettype wire

// ===== hw/rtl/lpht_ifs.sv =====
// Request and response channel interfaces of the hash table.
`default_nettype none
interface lpht_req_if import lpht_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [1:0]        action;
   logic [KEY_W-1:0]  key;
   logic [HASH_W-1:0] key_hash;
   logic [VAL_W-1:0]  value;
   modport source (output valid, action, key, key_hash, value, input ready);
   modport sink (input valid, action, key, key_hash, value, output ready);
endinterface

interface lpht_rsp_if import lpht_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [1:0]       status;
   logic [VAL_W-1:0] found_value;
   logic [CNT_W-1:0] entries;
   modport source (output valid, status, found_value, entries, input ready);
   modport sink (input valid, status, found_value, entries, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/linear_probe_hash_table.sv =====
// Open-addressing hash table with linear probing over one slot RAM.
//
//   channel | dir | handshake          | payload
//   req     | in  | req_if valid/ready | action, key, key_hash, value
//   rsp     | out | rsp_if valid/ready | status, found_value, entries
//   csr     | in  | csr_wr_en          | csr_wr_data (slots in use)
//
// An item computes its home slot remainder, then reads and compares each probed slot
// and loads the result; the next item is then taken in idle.
// A remove then reads each following cluster slot, clears it and reinserts it anew.
// Clear sweeps all 1024 slots, one per cycle; the same sweep runs after reset,
// while req_if.ready stays low.
// One item is in work at a time; a finished result waits in the output register.
`default_nettype none
`include "linear_probe_hash_table_defines.svh"
module linear_probe_hash_table import lpht_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   lpht_req_if.sink              req_if,
   lpht_rsp_if.source            rsp_if,
   input  wire logic             csr_wr_en,
   input  wire logic [CNT_W-1:0] csr_wr_data
);
   typedef enum logic [3:0] {
      S_IDLE, S_CLR, S_MOD, S_PRD, S_PCMP, S_RRD, S_RCMP, S_DONE
   } state_type;

   state_type         state_ff;
   logic [CNT_W-1:0]  cfg_ff;
   logic              init_ff;
   action_type        act_ff;
   logic              reins_ff;
   logic [HASH_W-1:0] hash_ff;
   logic [KEY_W-1:0]  key_ff;
   logic [VAL_W-1:0]  val_ff;
   logic [SLOT_AW-1:0] idx_ff;
   logic [SLOT_AW-1:0] k_ff;
   logic [SLOT_AW-1:0] home_ff;
   logic [CNT_W-1:0]  n_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  snap_ff;
   status_type        res_status_ff;
   logic [VAL_W-1:0]  res_found_ff;
   logic              rsp_valid_ff;
   logic [1:0]        rsp_status_ff;
   logic [VAL_W-1:0]  rsp_found_ff;
   logic [CNT_W-1:0]  rsp_entries_ff;

   logic [CNT_W-1:0]   size;
   logic [SLOT_AW-1:0] next_idx;
   logic [SLOT_AW-1:0] next_k;
   logic [CNT_W-1:0]   n_inc;
   logic [HASH_W-1:0]  req_hash;
   logic               accept;
   logic               rd_empty;
   logic               rd_hit;
   logic               ram_we;
   logic [SLOT_AW-1:0] ram_addr;
   slot_type           ram_wdata;
   slot_type           ram_rdata;
   mod_req_type        mod_req;
   mod_rsp_type        mod_rsp;

   always_comb begin
      if (cfg_ff == '0) begin
         size = CNT_W'(1);
      end else if (cfg_ff > CNT_W'(SLOTS)) begin
         size = CNT_W'(SLOTS);
      end else begin
         size = cfg_ff;
      end
      next_idx = ((CNT_W'(idx_ff) + 1'b1) >= size) ? '0 : idx_ff + 1'b1;
      next_k   = ((CNT_W'(k_ff) + 1'b1) >= size) ? '0 : k_ff + 1'b1;
      n_inc    = n_ff + 1'b1;
      req_hash = (req_if.key_hash == '0) ? '1 : req_if.key_hash;
      accept   = req_if.valid && req_if.ready;
      rd_empty = (ram_rdata.hash == '0);
      rd_hit   = (ram_rdata.hash == hash_ff) && (ram_rdata.key == key_ff);
   end

   assign req_if.ready = (state_ff == S_IDLE);

   // The reinsert of a cluster slot restarts the remainder unit on that slot's hash.
   always_comb begin
      mod_req.start    = 1'b0;
      mod_req.dividend = req_hash;
      mod_req.divisor  = size;
      if (state_ff == S_IDLE) begin
         mod_req.start = accept && (action_type'(req_if.action) != ACT_CLEAR);
      end else if (state_ff == S_RCMP) begin
         mod_req.start    = !rd_empty;
         mod_req.dividend = ram_rdata.hash;
      end
   end

   always_comb begin
      ram_we    = 1'b0;
      ram_addr  = idx_ff;
      ram_wdata = '0;
      case (state_ff)
         S_CLR: begin
            ram_we = 1'b1;
         end
         S_PCMP: begin
            if (rd_empty && (reins_ff || act_ff == ACT_INSERT)) begin
               ram_we    = 1'b1;
               ram_wdata = '{hash: hash_ff, key: key_ff, value: val_ff};
            end else if (!rd_empty && rd_hit && !reins_ff && act_ff == ACT_REMOVE) begin
               ram_we = 1'b1;
            end
         end
         S_RRD: begin
            ram_addr = k_ff;
         end
         S_RCMP: begin
            ram_addr = k_ff;
            ram_we   = !rd_empty;
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   lpht_ram #(
      .WIDTH($bits(slot_type)),
      .DEPTH(SLOTS)
   ) u_slots (
      .clock(clock),
      .we(ram_we),
      .addr(ram_addr),
      .wdata(ram_wdata),
      .rdata(ram_rdata)
   );

   lpht_mod u_mod (
      .clock(clock),
      .reset(reset),
      .req(mod_req),
      .rsp(mod_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         cfg_ff       <= CNT_W'(CFG_RESET);
         init_ff      <= 1'b1;
         idx_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            cfg_ff <= csr_wr_data;
         end
         // In S_DONE the output register is handled by the state itself.
         if (rsp_valid_ff && rsp_if.ready && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  act_ff        <= action_type'(req_if.action);
                  hash_ff       <= req_hash;
                  key_ff        <= req_if.key;
                  val_ff        <= req_if.value;
                  reins_ff      <= 1'b0;
                  res_status_ff <= ST_OK;
                  res_found_ff  <= '0;
                  if (action_type'(req_if.action) == ACT_CLEAR) begin
                     snap_ff  <= count_ff;
                     count_ff <= '0;
                     idx_ff   <= '0;
                     state_ff <= S_CLR;
                  end else begin
                     state_ff <= S_MOD;
                  end
               end
            end
            S_CLR: begin
               idx_ff <= idx_ff + 1'b1;
               if (idx_ff == SLOT_AW'(SLOTS - 1)) begin
                  init_ff  <= 1'b0;
                  state_ff <= init_ff ? S_IDLE : S_DONE;
               end
            end
            S_MOD: begin
               if (mod_rsp.done) begin
                  idx_ff <= mod_rsp.rem[SLOT_AW-1:0];
                  n_ff   <= '0;
                  if (!reins_ff) begin
                     home_ff <= mod_rsp.rem[SLOT_AW-1:0];
                  end
                  state_ff <= S_PRD;
               end
            end
            S_PRD: begin
               state_ff <= S_PCMP;
            end
            S_PCMP: begin
               if (rd_empty || rd_hit) begin
                  if (reins_ff) begin
                     k_ff     <= next_k;
                     state_ff <= (next_k == home_ff) ? S_DONE : S_RRD;
                  end else if (rd_empty) begin
                     if (act_ff == ACT_INSERT) begin
                        count_ff <= count_ff + 1'b1;
                     end else begin
                        res_status_ff <= ST_ABSENT;
                     end
                     state_ff <= S_DONE;
                  end else begin
                     res_status_ff <= ST_FOUND;
                     res_found_ff  <= ram_rdata.value;
                     if (act_ff == ACT_REMOVE) begin
                        if (count_ff != '0) begin
                           count_ff <= count_ff - 1'b1;
                        end
                        k_ff     <= next_idx;
                        state_ff <= S_RRD;
                     end else begin
                        state_ff <= S_DONE;
                     end
                  end
               end else if (n_inc == size) begin
                  // Every slot probed without a hit or an empty slot.
                  if (reins_ff) begin
                     k_ff     <= next_k;
                     state_ff <= (next_k == home_ff) ? S_DONE : S_RRD;
                  end else begin
                     res_status_ff <= (act_ff == ACT_INSERT) ? ST_FULL : ST_ABSENT;
                     state_ff      <= S_DONE;
                  end
               end else begin
                  n_ff     <= n_inc;
                  idx_ff   <= next_idx;
                  state_ff <= S_PRD;
               end
            end
            S_RRD: begin
               state_ff <= S_RCMP;
            end
            S_RCMP: begin
               if (rd_empty) begin
                  state_ff <= S_DONE;
               end else begin
                  hash_ff  <= ram_rdata.hash;
                  key_ff   <= ram_rdata.key;
                  val_ff   <= ram_rdata.value;
                  reins_ff <= 1'b1;
                  state_ff <= S_MOD;
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_if.ready) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_status_ff  <= res_status_ff;
                  rsp_found_ff   <= res_found_ff;
                  rsp_entries_ff <= (act_ff == ACT_CLEAR) ? snap_ff : count_ff;
                  state_ff       <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.status      = rsp_status_ff;
   assign rsp_if.found_value = rsp_found_ff;
   assign rsp_if.entries     = rsp_entries_ff;

   `LPHT_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(SLOTS))
   `LPHT_ASSERT_NEXT(a_one_in_work, clock, reset, accept, !req_if.ready)
   `LPHT_ASSERT_NOW(a_mod_done_waited, clock, reset, mod_rsp.done, state_ff == S_MOD)
   `LPHT_ASSERT_NOW(a_clear_blocks, clock, reset, state_ff == S_CLR, ram_we && !req_if.ready)
endmodule
`default_nettype wire

// ===== hw/rtl/lpht_ram.sv =====
// Generic single-port RAM with registered read data.
`default_nettype none
module lpht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule
`default_nettype wire

// ===== hw/rtl/lpht_mod.sv =====
// Bit-serial remainder unit: hash modulo table size, one dividend bit per cycle.
`default_nettype none
module lpht_mod import lpht_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire mod_req_type req,
   output mod_rsp_type      rsp
);
   logic              busy_ff;
   logic              done_ff;
   logic [MOD_CW-1:0] cnt_ff;
   logic [HASH_W-1:0] dvd_ff;
   logic [CNT_W-1:0]  div_ff;
   logic [CNT_W-1:0]  rem_ff;
   logic [CNT_W:0]    trial;
   logic [CNT_W:0]    diff;
   logic [CNT_W-1:0]  rem_in;

   always_comb begin
      trial  = {rem_ff, dvd_ff[HASH_W-1]};
      diff   = trial - {1'b0, div_ff};
      rem_in = (trial >= {1'b0, div_ff}) ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            dvd_ff  <= req.dividend;
            div_ff  <= req.divisor;
            rem_ff  <= '0;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            dvd_ff <= {dvd_ff[HASH_W-2:0], 1'b0};
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == MOD_CW'(HASH_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign rsp.done = done_ff;
   assign rsp.rem  = rem_ff;
endmodule
`default_nettype wire
